### rtl/uch_pkg.sv
// Shared types, constants and the byte-wide CRC-32 step for the update
// command handler. No dependencies.
`default_nettype none

package uch_pkg;

  // Frame layout: command byte plus a four-byte little-endian header word
  localparam int unsigned HdrBytes = 5;
  localparam int unsigned PosW     = 3;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // Status codes carried in each result
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ABORT = 3'd1,
    ST_SIZE  = 3'd2,
    ST_CRC   = 3'd3,
    ST_FLASH = 3'd4
  } status_t;

  // Configuration register indexes
  localparam logic [7:0] REG_START  = 8'd0;
  localparam logic [7:0] REG_WRITE  = 8'd1;
  localparam logic [7:0] REG_VERIFY = 8'd2;
  localparam logic [7:0] REG_ABORT  = 8'd3;

  // Frame view after the current byte has been applied
  typedef struct packed {
    logic [7:0]  cmd;
    logic [31:0] hdr;
    logic [31:0] crc;
    logic [31:0] cnt;
    logic        full;
  } frame_t;

  // One result item
  typedef struct packed {
    logic [31:0] checksum;
    logic [31:0] bytes;
    logic        restart;
    logic        active;
    status_t     status;
  } result_t;

  localparam int unsigned ResW   = $bits(result_t);
  localparam int unsigned OutDW  = ((ResW + 7) / 8) * 8;

  // Reflected CRC-32, one byte (eight shift steps)
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/uch_frame.sv
// Frame tracker: byte position, command, header word, running CRC and payload
// count of the frame in progress. Uses uch_pkg.
`default_nettype none

module uch_frame
  import uch_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_last,
  input  wire logic [31:0] committed_crc,
  output frame_t           cur
);

  logic [PosW-1:0] pos_r,  pos_nxt;
  logic [7:0]      cmd_r;
  logic [31:0]     hdr_r;
  logic [31:0]     crc_r;
  logic [31:0]     cnt_r;
  logic [PosW-1:0] pos_cur;

  // Apply the incoming byte to the frame so far
  always_comb begin
    cur.cmd = cmd_r;
    cur.hdr = hdr_r;
    cur.crc = crc_r;
    cur.cnt = cnt_r;
    pos_cur = pos_r;
    if (pos_r == '0) begin
      cur.cmd = frame_byte;
      cur.hdr = '0;
      cur.cnt = '0;
      cur.crc = ~committed_crc;
    end
    if (pos_r < PosW'(HdrBytes)) begin
      case (pos_r)
        3'd1:    cur.hdr[7:0]   = frame_byte;
        3'd2:    cur.hdr[15:8]  = frame_byte;
        3'd3:    cur.hdr[23:16] = frame_byte;
        3'd4:    cur.hdr[31:24] = frame_byte;
        default: ;
      endcase
      pos_cur = pos_r + PosW'(1);
    end else begin
      cur.crc = crc_byte(cur.crc, frame_byte);
      cur.cnt = cur.cnt + 32'd1;
    end
    cur.full = (pos_cur >= PosW'(HdrBytes));
    // last byte closes the frame
    pos_nxt = frame_last ? '0 : pos_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cmd_r <= '0;
      hdr_r <= '0;
      crc_r <= '1;
      cnt_r <= '0;
    end else if (acc) begin
      pos_r <= pos_nxt;
      cmd_r <= frame_last ? 8'd0  : cur.cmd;
      hdr_r <= frame_last ? 32'd0 : cur.hdr;
      crc_r <= frame_last ? '1    : cur.crc;
      cnt_r <= frame_last ? 32'd0 : cur.cnt;
    end
  end

endmodule

`default_nettype wire

### rtl/uch_cmd.sv
// Command executor: configuration codes, session state and the status
// decision on the last byte of each frame. Uses uch_pkg.
`default_nettype none

module uch_cmd
  import uch_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_idx,
  input  wire logic [7:0]  cfg_val,
  input  wire logic        acc,
  input  wire logic        frame_last,
  input  wire logic        flash_ok,
  input  frame_t           cur,
  output logic [31:0]      committed_crc,
  output logic             res_valid,
  output result_t          res
);

  logic [7:0]  start_code_r, write_code_r, verify_code_r, abort_code_r;
  logic        active_r,   active_nxt;
  logic [31:0] exp_len_r,  exp_len_nxt;
  logic [31:0] rx_len_r,   rx_len_nxt;
  logic [31:0] ccrc_r,     ccrc_nxt;

  assign committed_crc = ccrc_r;
  assign res_valid     = acc && frame_last;

  // Decide the command outcome, first match wins
  always_comb begin
    active_nxt  = active_r;
    exp_len_nxt = exp_len_r;
    rx_len_nxt  = rx_len_r;
    ccrc_nxt    = ccrc_r;
    res.status  = ST_ABORT;
    res.restart = 1'b0;
    if (cur.cmd == start_code_r) begin
      if (!cur.full) begin
        res.status = ST_SIZE;
      end else begin
        exp_len_nxt = cur.hdr;
        if (!flash_ok) begin
          res.status = ST_FLASH;
        end else begin
          active_nxt = 1'b1;
          rx_len_nxt = '0;
          ccrc_nxt   = '0;
          res.status = ST_OK;
        end
      end
    end else if (cur.cmd == write_code_r) begin
      if (!active_r) begin
        res.status = ST_ABORT;
      end else if (!cur.full) begin
        res.status = ST_SIZE;
      end else if (!flash_ok) begin
        active_nxt = 1'b0;
        res.status = ST_FLASH;
      end else begin
        ccrc_nxt   = ~cur.crc;
        rx_len_nxt = rx_len_r + cur.cnt;
        res.status = ST_OK;
      end
    end else if (cur.cmd == verify_code_r) begin
      if (!active_r) begin
        res.status = ST_ABORT;
      end else if (!cur.full) begin
        res.status = ST_SIZE;
      end else begin
        active_nxt = 1'b0;
        if (rx_len_r != exp_len_r) begin
          res.status = ST_SIZE;
        end else if (ccrc_r != cur.hdr) begin
          res.status = ST_CRC;
        end else if (!flash_ok) begin
          res.status = ST_FLASH;
        end else begin
          res.status  = ST_OK;
          res.restart = 1'b1;
        end
      end
    end else if (cur.cmd == abort_code_r) begin
      active_nxt = 1'b0;
      rx_len_nxt = '0;
      res.status = ST_ABORT;
    end
    res.active   = active_nxt;
    res.bytes    = rx_len_nxt;
    res.checksum = ccrc_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r  <= 8'd0;
      write_code_r  <= 8'd1;
      verify_code_r <= 8'd2;
      abort_code_r  <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_START:  start_code_r  <= cfg_val;
        REG_WRITE:  write_code_r  <= cfg_val;
        REG_VERIFY: verify_code_r <= cfg_val;
        REG_ABORT:  abort_code_r  <= cfg_val;
        default: ;
      endcase
    end
  end

  // Session state, updated only when a frame completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      exp_len_r <= '0;
      rx_len_r  <= '0;
      ccrc_r    <= '0;
    end else if (res_valid) begin
      active_r  <= active_nxt;
      exp_len_r <= exp_len_nxt;
      rx_len_r  <= rx_len_nxt;
      ccrc_r    <= ccrc_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/uch_outbuf.sv
// Result buffer: output register plus one skid entry so the input side
// keeps moving while a result waits. Uses uch_pkg.
`default_nettype none

module uch_outbuf
  import uch_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  input  result_t   res,
  output logic      room,
  output logic      out_valid,
  input  wire logic out_ready,
  output result_t   out_res
);

  logic    ov_r, ov_nxt;
  logic    sv_r, sv_nxt;
  result_t od_r, od_nxt;
  result_t sd_r, sd_nxt;

  assign room      = !sv_r;
  assign out_valid = ov_r;
  assign out_res   = od_r;

  // Move skid into output when it drains; park a new result when stalled
  always_comb begin
    ov_nxt = ov_r;
    sv_nxt = sv_r;
    od_nxt = od_r;
    sd_nxt = sd_r;
    if (ov_r && !out_ready) begin
      if (res_valid) begin
        sv_nxt = 1'b1;
        sd_nxt = res;
      end
    end else if (sv_r) begin
      ov_nxt = 1'b1;
      od_nxt = sd_r;
      sv_nxt = 1'b0;
    end else begin
      ov_nxt = res_valid;
      od_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
    od_r <= od_nxt;
    sd_r <= sd_nxt;
  end

endmodule

`default_nettype wire

### rtl/update_command_handler_crc32.sv
// Top level of the firmware-update command handler with reflected CRC-32.
// Instantiates uch_frame, uch_cmd and uch_outbuf; uses uch_pkg.
//
//   channel | direction | handshake          | payload
//   in_     | slave     | in_tvalid/tready   | tdata=frame_byte, tlast=frame_last, tuser=flash_ok
//   out_    | master    | out_tvalid/tready  | tdata=status,session_active,restart,bytes,crc
//   cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data
//
// One byte per cycle while in_tready is high; the CRC byte step and header capture
// finish in the accept cycle, and a frame's status is registered into the output
// register, or into the skid entry when the output stalls. A two-entry output
// (register plus skid) lets input continue while one result is stalled; in_tready
// drops only when both are full. Synchronous active-low reset; cfg_ready is always high.
`default_nettype none

module update_command_handler_crc32
  import uch_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] frame_byte
  input  wire logic             in_tlast,   // frame_last
  input  wire logic             in_tuser,   // [0] flash_ok
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OutDW-1:0]      out_tdata,  // [2:0] status, [3] session_active,
                                            // [4] restart_request, [36:5] bytes_received,
                                            // [68:37] image_checksum, rest zero
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_index,
  input  wire logic [7:0]       cfg_data
);

  logic        acc;
  logic        room;
  frame_t      cur;
  logic [31:0] committed_crc;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign in_tready = room;
  assign acc       = in_tvalid && room;
  assign cfg_ready = 1'b1;
  assign out_tdata = {{(OutDW-ResW){1'b0}}, out_res};

  uch_frame u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .frame_byte    (in_tdata),
    .frame_last    (in_tlast),
    .committed_crc (committed_crc),
    .cur           (cur)
  );

  uch_cmd u_cmd (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_idx       (cfg_index),
    .cfg_val       (cfg_data),
    .acc           (acc),
    .frame_last    (in_tlast),
    .flash_ok      (in_tuser),
    .cur           (cur),
    .committed_crc (committed_crc),
    .res_valid     (res_valid),
    .res           (res)
  );

  uch_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

### rtl/uch_checker.sv
// Port-level checks for the update command handler, bound to the top level.
// Uses uch_pkg for the output layout.
`default_nettype none

module uch_checker
  import uch_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OutDW-1:0] out_tdata
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_FLASH)
    else $error("undefined status code");

  // A reboot request only follows a good verify, which closes the session
  a_restart_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[2:0] == ST_OK && !out_tdata[3])
    else $error("restart without successful verify");

  // Padding bits above the result are zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OutDW-1:ResW] == '0)
    else $error("nonzero padding in result");

endmodule

bind update_command_handler_crc32 uch_checker u_uch_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
